@@ hdl/assert_macros.svh @@
// Assertion helper macros shared by the RTL files.
// Depends on: a clk_i clock and an active-low rst_ni reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dprc_pkg.sv @@
// Shared constants and types for the detrended peak rate counter.
// No dependencies; used by dprc_walk and detrended_peak_rate_counter.
`timescale 1ns / 1ps

package dprc_pkg;

  // Register field widths and reset values
  localparam int WLEN_W    = 7;
  localparam int SCALE_W   = 6;
  localparam int LIMIT_W   = 12;
  localparam int WLEN_RST  = 50;
  localparam int SCALE_RST = 6;
  localparam int LIMIT_RST = 80;

  // Result field widths and saturation limits
  localparam int COUNT_W   = 7;
  localparam int RATE_W    = 12;
  localparam int COUNT_MAX = 127;
  localparam int RATE_MAX  = 4095;

  // Smallest usable window
  localparam int MIN_WINDOW = 3;

  // Configuration port geometry
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_WLEN  = 2'd0,
    REG_SCALE = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_e;

  // Walk engine result, one strobe per window
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] peaks;
    logic [COUNT_W-1:0] above;
  } walk_res_t;

endpackage

@@ hdl/dprc_mem.sv @@
// Sample store: single write port, single read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module dprc_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one entry per beat
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read: data appears in the cycle after rd_en_i
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/dprc_walk.sv @@
// Line fit setup and sample walk: derives the trend terms from the running sums,
// then streams the stored window once and counts samples above the line and peaks.
// Depends on dprc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dprc_walk #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   n_i,
  input  logic [$clog2(longint'(MAX_WINDOW) *
                 ((longint'(1) << SAMPLE_BITS) - 1) + 1)-1:0] sy_i,
  input  logic [$clog2(longint'(MAX_WINDOW) * (MAX_WINDOW + 1) / 2 *
                 ((longint'(1) << SAMPLE_BITS) - 1) + 1)-1:0] sxy_i,
  output logic                              rd_en_o,
  output logic [$clog2(MAX_WINDOW)-1:0]     rd_addr_o,
  input  logic [SAMPLE_BITS-1:0]            rd_data_i,
  output dprc_pkg::walk_res_t               res_o
);

  import dprc_pkg::*;

  // Widths follow from the window and sample sizes
  localparam int NW  = $clog2(MAX_WINDOW + 1);
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int SYW = $clog2(longint'(MAX_WINDOW) * ((longint'(1) << SAMPLE_BITS) - 1) + 1);
  localparam int WSW = $clog2(longint'(MAX_WINDOW) * (MAX_WINDOW + 1) / 2 *
                              ((longint'(1) << SAMPLE_BITS) - 1) + 1);
  localparam int PW  = $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int QW  = $clog2(longint'(MAX_WINDOW) * (MAX_WINDOW * MAX_WINDOW - 1) + 1);
  localparam int MW  = WSW + 2;
  localparam int LW  = QW + SAMPLE_BITS;
  localparam int C1  = (LW + 1 > PW + SYW + 1) ? LW + 1 : PW + SYW + 1;
  localparam int C2  = (C1 > MW + NW + 3) ? C1 : MW + NW + 3;
  localparam int CW  = C2 + 2;
  localparam int CNTW = (NW > COUNT_W) ? NW : COUNT_W;

  typedef enum logic [2:0] {
    W_IDLE,
    W_SETUP1,
    W_SETUP2,
    W_SETUP3,
    W_SETUP4,
    W_WALK
  } walk_state_e;

  walk_state_e state_q;
  logic [NW-1:0] rd_cnt_q;
  logic          rvld_q;
  logic          cv_q;
  logic [NW-1:0] above_q;
  logic [NW-1:0] peak_q;
  walk_res_t     res_q;

  // Fit terms (scaled by n(n^2-1) so that only integers remain):
  //   n(n^2-1)*a  >  (n^2-1)*Sy + 3*M*(2x-n-1),  M = 2*Sxy - (n+1)*Sy
  logic [PW-1:0]              p_q;
  logic [WSW:0]               t1_q;
  logic [QW-1:0]              q_q;
  logic signed [MW-1:0]       m_q;
  logic [PW+SYW-1:0]          psy_q;
  logic signed [MW+NW-1:0]    mn_q;
  logic signed [CW-1:0]       rhs_q;
  logic signed [MW+2:0]       step_q;
  logic [LW-1:0]              prod_q;
  logic [SAMPLE_BITS-1:0]     cur_q;
  logic [SAMPLE_BITS-1:0]     prv_q;

  logic [2*NW-1:0]            nsq;
  logic [2*NW-1:0]            nsq_m1;
  logic [NW:0]                n_p1;
  logic [NW-1:0]              n_m1;
  logic [NW+SYW:0]            t1_full;
  logic [NW+PW-1:0]           q_full;
  logic [PW+SYW-1:0]          psy_full;
  logic signed [MW-1:0]       m_d;
  logic signed [MW+NW-1:0]    mn_d;
  logic signed [CW-1:0]       rhs_init;
  logic signed [MW+2:0]       step_d;
  logic [LW-1:0]              prod_d;
  logic [SAMPLE_BITS-1:0]     nxt;
  logic signed [CW-1:0]       lhs;
  logic                       above_hit;
  logic                       peak_hit;
  logic [NW-1:0]              above_nx;
  logic [NW-1:0]              peak_nx;
  logic [CNTW-1:0]            above_ext;
  logic [CNTW-1:0]            peak_ext;
  logic [COUNT_W-1:0]         above_sat;
  logic [COUNT_W-1:0]         peak_sat;

  // Setup arithmetic, one multiplier per path per stage
  always_comb begin
    nsq      = n_i * n_i;
    nsq_m1   = nsq - 1'b1;
    n_p1     = {1'b0, n_i} + 1'b1;
    n_m1     = n_i - 1'b1;
    t1_full  = n_p1 * sy_i;
    q_full   = n_i * p_q;
    psy_full = p_q * sy_i;
    m_d      = $signed({1'b0, sxy_i, 1'b0}) - $signed({1'b0, t1_q});
    mn_d     = m_q * $signed({1'b0, n_m1});
    rhs_init = CW'($signed({1'b0, psy_q})) - (CW'(mn_q) <<< 1) - CW'(mn_q);
    step_d   = ((MW+3)'(m_q) <<< 2) + ((MW+3)'(m_q) <<< 1);
  end

  // Walk datapath: the sample in cur_q is judged once its right neighbor arrives
  always_comb begin
    rd_en_o   = (state_q == W_WALK) && (rd_cnt_q != n_i);
    rd_addr_o = rd_cnt_q[AW-1:0];
    prod_d    = q_q * rd_data_i;
    nxt       = rvld_q ? rd_data_i : '0;
    lhs       = CW'($signed({1'b0, prod_q}));
    above_hit = lhs > rhs_q;
    peak_hit  = above_hit && (cur_q > prv_q) && (cur_q > nxt);
    above_nx  = above_q + NW'(above_hit);
    peak_nx   = peak_q + NW'(peak_hit);
    above_ext = CNTW'(above_nx);
    peak_ext  = CNTW'(peak_nx);
    above_sat = (above_ext > CNTW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : above_ext[COUNT_W-1:0];
    peak_sat  = (peak_ext > CNTW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : peak_ext[COUNT_W-1:0];
  end

  // Sequencer: setup stages, then one read beat per stored sample plus a flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      rd_cnt_q <= '0;
      rvld_q   <= 1'b0;
      cv_q     <= 1'b0;
      above_q  <= '0;
      peak_q   <= '0;
      res_q    <= '0;
    end else begin
      res_q.done <= 1'b0;
      rvld_q     <= rd_en_o;
      case (state_q)
        W_IDLE: begin
          if (start_i) begin
            rd_cnt_q <= '0;
            cv_q     <= 1'b0;
            above_q  <= '0;
            peak_q   <= '0;
            state_q  <= W_SETUP1;
          end
        end
        W_SETUP1: state_q <= W_SETUP2;
        W_SETUP2: state_q <= W_SETUP3;
        W_SETUP3: state_q <= W_SETUP4;
        W_SETUP4: state_q <= W_WALK;
        W_WALK: begin
          if (rd_en_o) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (cv_q) begin
            above_q <= above_nx;
            peak_q  <= peak_nx;
          end
          if (rvld_q) begin
            cv_q <= 1'b1;
          end else if (cv_q) begin
            // last sample judged against a zero right neighbor
            cv_q        <= 1'b0;
            res_q.done  <= 1'b1;
            res_q.above <= above_sat;
            res_q.peaks <= peak_sat;
            state_q     <= W_IDLE;
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      W_IDLE: begin
        prv_q <= '0;
      end
      W_SETUP1: begin
        p_q  <= nsq_m1[PW-1:0];
        t1_q <= t1_full[WSW:0];
      end
      W_SETUP2: begin
        q_q   <= q_full[QW-1:0];
        m_q   <= m_d;
        psy_q <= psy_full;
      end
      W_SETUP3: begin
        mn_q <= mn_d;
      end
      W_SETUP4: begin
        rhs_q  <= rhs_init;
        step_q <= step_d;
      end
      W_WALK: begin
        if (rvld_q) begin
          prv_q  <= cv_q ? cur_q : '0;
          cur_q  <= rd_data_i;
          prod_q <= prod_d;
          if (cv_q) begin
            rhs_q <= rhs_q + CW'(step_q);
          end
        end
      end
      default: begin
        prv_q <= '0;
      end
    endcase
  end

  assign res_o = res_q;

  `ASSERT_IMPL(a_peaks_le_above, res_o.done, res_o.peaks <= res_o.above,
               "peak count exceeds above count")
  `ASSERT_IMPL(a_start_when_idle, start_i, state_q == W_IDLE,
               "walk started while a window is in progress")

endmodule

@@ hdl/detrended_peak_rate_counter.sv @@
// Top level of the detrended peak rate counter: configuration registers, sample
// collection with running sums, and rate/alarm formation.
// Depends on dprc_pkg, dprc_mem, dprc_walk and assert_macros.svh.
//
// Usage:
//   Samples enter on sample_i when start is high and busy is low, one beat per
//   cycle. Each sample is written into the sample memory and added to the value
//   sum and the position-weighted sum. The sample that fills the window raises
//   busy; the block then fits the trend line and walks the stored window.
//   After the edge that takes that last sample (n = samples in the window),
//   the walk is launched, four setup stages form the fit terms, one memory
//   read is issued per stored sample (n reads), the read data is registered,
//   a flush judges the last sample, the counts are handed over, and rate and
//   alarm are formed. done_o then pulses for one cycle with peak_count_o,
//   above_count_o, rate_o and alarm_o. busy holds off new samples meanwhile.
//   busy falls in the cycle done_o rises, so the next window may start at once.
//   The receiver cannot stall; a result is present only while done_o is high.
//   The APB port reads and writes window_length (0x0), rate_scale (0x4) and
//   alarm_limit (0x8); writes are meant for idle periods only.
//   Reset empties the window, clears the sums and loads 50, 6 and 80 into the
//   registers. The sample memory needs no clearing: only entries written in
//   the current window are read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module detrended_peak_rate_counter #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                            done_o,
  output logic [dprc_pkg::COUNT_W-1:0]    peak_count_o,
  output logic [dprc_pkg::COUNT_W-1:0]    above_count_o,
  output logic [dprc_pkg::RATE_W-1:0]     rate_o,
  output logic                            alarm_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dprc_pkg::CFG_AW-1:0]     paddr,
  input  logic [dprc_pkg::CFG_DW-1:0]     pwdata,
  output logic [dprc_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);

  import dprc_pkg::*;

  localparam int NW  = $clog2(MAX_WINDOW + 1);
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int SYW = $clog2(longint'(MAX_WINDOW) * ((longint'(1) << SAMPLE_BITS) - 1) + 1);
  localparam int WSW = $clog2(longint'(MAX_WINDOW) * (MAX_WINDOW + 1) / 2 *
                              ((longint'(1) << SAMPLE_BITS) - 1) + 1);
  localparam int EW  = (NW > WLEN_W) ? NW : WLEN_W;
  localparam int RFW = COUNT_W + SCALE_W;

  typedef enum logic [1:0] {
    T_FILL,
    T_WALK,
    T_RATE,
    T_OUT
  } top_state_e;

  top_state_e state_q;

  logic [WLEN_W-1:0]  wlen_q;
  logic [SCALE_W-1:0] scale_q;
  logic [LIMIT_W-1:0] limit_q;

  logic [NW-1:0]      fill_q;
  logic [SYW-1:0]     sy_q;
  logic [WSW-1:0]     sxy_q;
  logic               walk_start_q;
  logic               done_q;
  logic [COUNT_W-1:0] peak_q;
  logic [COUNT_W-1:0] above_q;
  logic [RATE_W-1:0]  rate_q;
  logic               alarm_q;

  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  logic               accept;
  logic               mem_wr;
  logic [NW-1:0]      fill_nx;
  logic [NW+SAMPLE_BITS-1:0] wprod;
  logic [EW-1:0]      wlen_ext;
  logic [EW-1:0]      eff_len;
  logic               win_full;
  logic [RFW-1:0]     rate_full;
  logic [RATE_W-1:0]  rate_sat;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  walk_res_t              walk_res;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q  <= WLEN_W'(WLEN_RST);
      scale_q <= SCALE_W'(SCALE_RST);
      limit_q <= LIMIT_W'(LIMIT_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WLEN:  wlen_q  <= pwdata[WLEN_W-1:0];
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
        default:   wlen_q  <= wlen_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WLEN:  prdata = CFG_DW'(wlen_q);
      REG_SCALE: prdata = CFG_DW'(scale_q);
      REG_LIMIT: prdata = CFG_DW'(limit_q);
      default:   prdata = '0;
    endcase
  end

  // Sample intake and window length clamp
  always_comb begin
    accept   = start && !busy;
    mem_wr   = accept && (fill_q < NW'(MAX_WINDOW));
    fill_nx  = fill_q + 1'b1;
    wprod    = fill_nx * sample_i;
    wlen_ext = EW'(wlen_q);
    if (wlen_ext < EW'(MIN_WINDOW)) begin
      eff_len = EW'(MIN_WINDOW);
    end else if (wlen_ext > EW'(MAX_WINDOW)) begin
      eff_len = EW'(MAX_WINDOW);
    end else begin
      eff_len = wlen_ext;
    end
    win_full = EW'(fill_nx) >= eff_len;
  end

  // Rate with saturation
  always_comb begin
    rate_full = peak_q * scale_q;
    rate_sat  = (rate_full > RFW'(RATE_MAX)) ? RATE_W'(RATE_MAX) : rate_full[RATE_W-1:0];
  end

  assign busy = (state_q != T_FILL);

  // Control: collect, hand the window to the walk, form the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_FILL;
      fill_q       <= '0;
      sy_q         <= '0;
      sxy_q        <= '0;
      walk_start_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      walk_start_q <= 1'b0;
      done_q       <= 1'b0;
      case (state_q)
        T_FILL: begin
          if (mem_wr) begin
            fill_q <= fill_nx;
            sy_q   <= sy_q + SYW'(sample_i);
            sxy_q  <= sxy_q + WSW'(wprod);
          end
          if (accept && win_full) begin
            walk_start_q <= 1'b1;
            state_q      <= T_WALK;
          end
        end
        T_WALK: begin
          if (walk_res.done) begin
            fill_q  <= '0;
            sy_q    <= '0;
            sxy_q   <= '0;
            state_q <= T_RATE;
          end
        end
        T_RATE: state_q <= T_OUT;
        T_OUT: begin
          done_q  <= 1'b1;
          state_q <= T_FILL;
        end
        default: state_q <= T_FILL;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (walk_res.done) begin
      peak_q  <= walk_res.peaks;
      above_q <= walk_res.above;
    end
    if (state_q == T_RATE) begin
      rate_q <= rate_sat;
    end
    if (state_q == T_OUT) begin
      alarm_q <= (LIMIT_W'(rate_q) > limit_q);
    end
  end

  assign done_o        = done_q;
  assign peak_count_o  = peak_q;
  assign above_count_o = above_q;
  assign rate_o        = rate_q;
  assign alarm_o       = alarm_q;

  // Sample memory; writes and walk reads never overlap, as busy holds off intake
  dprc_mem #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (fill_q[AW-1:0]),
    .wr_data_i (sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dprc_walk #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (walk_start_q),
    .n_i       (fill_q),
    .sy_i      (sy_q),
    .sxy_i     (sxy_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .res_o     (walk_res)
  );

  `ASSERT_IMPL(a_done_not_busy, done_o, !busy, "result beat while busy")
  `ASSERT_NEXT(a_full_goes_busy, accept && win_full, busy,
               "window completed without raising busy")

endmodule
